>>> hdl/sse_pkg.sv
`default_nettype none
package sse_pkg;

    localparam logic [1:0] OP_FEED      = 2'd0;
    localparam logic [1:0] OP_READ_NAME = 2'd1;
    localparam logic [1:0] OP_READ_DATA = 2'd2;
    localparam logic [1:0] OP_STOP      = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_STOPPED  = 2'd2;

    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_SKIP     = 4'd1;
    localparam logic [3:0] PH_EV1      = 4'd2;
    localparam logic [3:0] PH_EV2      = 4'd3;
    localparam logic [3:0] PH_EV3      = 4'd4;
    localparam logic [3:0] PH_EV4      = 4'd5;
    localparam logic [3:0] PH_EV5      = 4'd6;
    localparam logic [3:0] PH_DA1      = 4'd7;
    localparam logic [3:0] PH_DA2      = 4'd8;
    localparam logic [3:0] PH_DA3      = 4'd9;
    localparam logic [3:0] PH_DA4      = 4'd10;
    localparam logic [3:0] PH_EV_FIRST = 4'd11;
    localparam logic [3:0] PH_EV_VAL   = 4'd12;
    localparam logic [3:0] PH_DA_FIRST = 4'd13;
    localparam logic [3:0] PH_DA_VAL   = 4'd14;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Store write request from the parser to the buffer memories.
    typedef struct packed {
        logic        name_we;
        logic        data_we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } store_wr_t;

    // Next expected letter of the field name, given the current phase.
    function automatic logic [7:0] word_char(input logic [3:0] ph);
        logic [7:0] c;
        c = 8'h00;
        unique case (ph)
            PH_START: c = 8'h65;
            PH_EV1:   c = 8'h76;
            PH_EV2:   c = 8'h65;
            PH_EV3:   c = 8'h6E;
            PH_EV4:   c = 8'h74;
            PH_DA1:   c = 8'h61;
            PH_DA2:   c = 8'h74;
            PH_DA3:   c = 8'h61;
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/sse_store.sv
`default_nettype none
module sse_store #(
    parameter int NAME_BYTES = 64,
    parameter int DATA_BYTES = 4096
) (
    input  wire logic              aclk,
    input  wire sse_pkg::store_wr_t wr,
    input  wire logic [11:0]       rd_index,
    output logic [7:0]             name_q,
    output logic [7:0]             data_q
);
    localparam int NW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int DW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

    logic [7:0] name_mem [NAME_BYTES];
    logic [7:0] data_mem [DATA_BYTES];
    logic [DW-1:0] data_rd;
    logic [NW-1:0] name_rd;

    // out-of-range indexes wrap here; the caller masks their read result to zero
    always_comb begin
        data_rd = DW'(rd_index);
        name_rd = NW'(rd_index);
    end

    always_ff @(posedge aclk) begin
        if (wr.name_we) begin
            name_mem[wr.addr[NW-1:0]] <= wr.wdata;
        end
        if (wr.data_we) begin
            data_mem[wr.addr[DW-1:0]] <= wr.wdata;
        end
        name_q <= name_mem[name_rd];
        data_q <= data_mem[data_rd];
    end
endmodule
`default_nettype wire

>>> hdl/sse_event_stream_parser.sv
`default_nettype none
// Server-Sent Events parser. One request per cycle on s_axis (tdata: operation[1:0],
// in_byte[9:2], read_index[21:10]); one result per request on m_axis. A feed
// request advances the line parser and writes value bytes straight into the name
// and data memories; a blank line dispatches a pending event with its lengths.
// Read requests fetch a memory byte; a stop request latches stopped. Throughput is
// one request per cycle. The memories have a registered read port, so the
// result passes through a hold stage and then enters a two-entry
// output queue; when the queue is full, s_axis_tready follows m_axis_tready.
// Input is not taken while aresetn is low. Only the stream order sets the bytes
// read: a read sees all earlier feeds because each write lands at the edge where
// the feed is accepted.
module sse_event_stream_parser #(
    parameter int LINE_BYTES = 1024,
    parameter int NAME_BYTES = 64,
    parameter int DATA_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // operation, in_byte, read_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // status, event_ready, name_length,
                                            // data_length, read_byte
);
    localparam int LW = $clog2(LINE_BYTES + 1);

    logic [1:0]  op;
    logic [7:0]  c;
    logic [11:0] idx;
    logic        acc;
    assign op  = s_axis_tdata[1:0];
    assign c   = s_axis_tdata[9:2];
    assign idx = s_axis_tdata[21:10];
    assign acc = s_axis_tvalid && s_axis_tready;

    logic [LW-1:0] line_reg, line_next;
    logic [3:0]    ph_reg, ph_next;
    logic [16:0]   vcnt_reg, vcnt_next;
    logic [10:0]   ncnt_reg, ncnt_next;
    logic [16:0]   dcnt_reg, dcnt_next;
    logic          cr_reg, cr_next, pend_reg, pend_next;
    logic          ovf_reg, ovf_next, stop_reg, stop_next;
    logic          evr;
    logic [5:0]    nlen;
    logic [11:0]   dlen;
    sse_pkg::store_wr_t wr;

    logic [LW-1:0] llen;
    logic [16:0]   vlen;
    logic [17:0]   total, pos;
    logic          join_b;

    always_comb begin
        line_next = line_reg; ph_next = ph_reg; vcnt_next = vcnt_reg;
        ncnt_next = ncnt_reg; dcnt_next = dcnt_reg; cr_next = cr_reg;
        pend_next = pend_reg; ovf_next = ovf_reg; stop_next = stop_reg;
        evr = 1'b0; nlen = '0; dlen = '0;
        wr = '0;
        join_b = (dcnt_reg != '0);
        llen = line_reg - LW'(cr_reg);
        vlen = vcnt_reg;
        if ((ph_reg == sse_pkg::PH_EV_VAL || ph_reg == sse_pkg::PH_DA_VAL)
            && cr_reg && vcnt_reg != '0) begin
            vlen = vcnt_reg - 17'd1;
        end
        total = 18'(dcnt_reg) + 18'(join_b) + 18'(vlen) + 18'd1;
        pos   = 18'(dcnt_reg) + 18'(join_b) + 18'(vcnt_reg);
        if (acc) begin
            unique case (op)
                sse_pkg::OP_FEED: begin
                    if (!ovf_reg && !stop_reg) begin
                        if (c == sse_pkg::CH_LF) begin
                            if (llen == '0) begin
                                if (pend_reg) begin
                                    evr = 1'b1;
                                    nlen = ncnt_reg[5:0];
                                    dlen = dcnt_reg[11:0];
                                end
                                ncnt_next = '0; dcnt_next = '0; pend_next = 1'b0;
                            end else if (ph_reg == sse_pkg::PH_EV_FIRST
                                         || ph_reg == sse_pkg::PH_EV_VAL) begin
                                if (vlen >= 17'(NAME_BYTES)) ovf_next = 1'b1;
                                else begin
                                    ncnt_next = 11'(vlen); pend_next = 1'b1;
                                end
                            end else if (ph_reg == sse_pkg::PH_DA_FIRST
                                         || ph_reg == sse_pkg::PH_DA_VAL) begin
                                if (total > 18'(DATA_BYTES)) ovf_next = 1'b1;
                                else begin
                                    if (join_b) begin
                                        wr.data_we = 1'b1;
                                        wr.addr = 16'(dcnt_reg);
                                        wr.wdata = sse_pkg::CH_LF;
                                    end
                                    dcnt_next = 17'(dcnt_reg + 17'(join_b) + vlen);
                                    pend_next = 1'b1;
                                end
                            end
                            line_next = '0; vcnt_next = '0; cr_next = 1'b0;
                            ph_next = sse_pkg::PH_START;
                        end else if (32'(line_reg) + 32'd1 >= 32'(LINE_BYTES)) begin
                            ovf_next = 1'b1;
                        end else begin
                            // value bytes go to memory as they arrive
                            if (((ph_reg == sse_pkg::PH_EV_FIRST
                                  || ph_reg == sse_pkg::PH_DA_FIRST)
                                 && c != sse_pkg::CH_SPACE)
                                || ph_reg == sse_pkg::PH_EV_VAL
                                || ph_reg == sse_pkg::PH_DA_VAL) begin
                                if (ph_reg == sse_pkg::PH_EV_FIRST
                                    || ph_reg == sse_pkg::PH_EV_VAL) begin
                                    wr.name_we = (vcnt_reg < 17'(NAME_BYTES));
                                end else begin
                                    wr.data_we = (pos < 18'(DATA_BYTES));
                                end
                                wr.addr = (ph_reg == sse_pkg::PH_EV_FIRST
                                           || ph_reg == sse_pkg::PH_EV_VAL)
                                          ? 16'(vcnt_reg) : 16'(pos);
                                wr.wdata = c;
                                vcnt_next = vcnt_reg + 17'd1;
                            end
                            if (ph_reg == sse_pkg::PH_EV_FIRST) begin
                                ph_next = sse_pkg::PH_EV_VAL;
                            end else if (ph_reg == sse_pkg::PH_DA_FIRST) begin
                                ph_next = sse_pkg::PH_DA_VAL;
                            end else if (ph_reg == sse_pkg::PH_EV_VAL
                                         || ph_reg == sse_pkg::PH_DA_VAL
                                         || ph_reg == sse_pkg::PH_SKIP) begin
                                ph_next = ph_reg;
                            end else if (c == sse_pkg::CH_COLON) begin
                                ph_next = (ph_reg == sse_pkg::PH_EV5) ? sse_pkg::PH_EV_FIRST
                                        : (ph_reg == sse_pkg::PH_DA4) ? sse_pkg::PH_DA_FIRST
                                        : sse_pkg::PH_SKIP;
                            end else if (ph_reg == sse_pkg::PH_START) begin
                                ph_next = (c == 8'h65) ? sse_pkg::PH_EV1
                                        : (c == 8'h64) ? sse_pkg::PH_DA1
                                        : sse_pkg::PH_SKIP;
                            end else if ((ph_reg >= sse_pkg::PH_EV1
                                          && ph_reg < sse_pkg::PH_EV5)
                                         || (ph_reg >= sse_pkg::PH_DA1
                                             && ph_reg < sse_pkg::PH_DA4)) begin
                                ph_next = (c == sse_pkg::word_char(ph_reg))
                                        ? ph_reg + 4'd1 : sse_pkg::PH_SKIP;
                            end else begin
                                ph_next = sse_pkg::PH_SKIP;
                            end
                            line_next = line_reg + LW'(1);
                            cr_next = (c == sse_pkg::CH_CR);
                        end
                    end
                end
                sse_pkg::OP_READ_NAME: ;
                sse_pkg::OP_READ_DATA: ;
                sse_pkg::OP_STOP: stop_next = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= '0; ph_reg <= sse_pkg::PH_START; vcnt_reg <= '0;
            ncnt_reg <= '0; dcnt_reg <= '0; cr_reg <= 1'b0; pend_reg <= 1'b0;
            ovf_reg <= 1'b0; stop_reg <= 1'b0;
        end else begin
            line_reg <= line_next; ph_reg <= ph_next; vcnt_reg <= vcnt_next;
            ncnt_reg <= ncnt_next; dcnt_reg <= dcnt_next; cr_reg <= cr_next;
            pend_reg <= pend_next; ovf_reg <= ovf_next; stop_reg <= stop_next;
        end
    end

    logic [7:0] name_q, data_q;
    sse_store #(.NAME_BYTES(NAME_BYTES), .DATA_BYTES(DATA_BYTES)) u_store (
        .aclk(aclk), .wr(wr), .rd_index(idx), .name_q(name_q), .data_q(data_q)
    );

    // stage 1: hold the result fields while the memory read completes
    logic        p1_v_reg, p1_rn_reg, p1_rd_reg;
    logic [20:0] p1_f_reg;
    logic [1:0]  st_now;
    assign st_now = ovf_next ? sse_pkg::ST_OVERFLOW
                  : (stop_next ? sse_pkg::ST_STOPPED : sse_pkg::ST_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) p1_v_reg <= 1'b0;
        else          p1_v_reg <= acc;
        p1_rn_reg <= (op == sse_pkg::OP_READ_NAME) && (32'(idx) < 32'(NAME_BYTES));
        p1_rd_reg <= (op == sse_pkg::OP_READ_DATA) && (32'(idx) < 32'(DATA_BYTES));
        p1_f_reg  <= {dlen, nlen, evr, st_now};
    end

    logic [31:0] p1_word;
    assign p1_word = {3'b000,
                      p1_rn_reg ? name_q : (p1_rd_reg ? data_q : 8'h00),
                      p1_f_reg};

    // two-entry skid queue; ready looks at free space so stage 1 never drops
    logic [31:0] q_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;
    assign pop = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = q_reg[0];
    // hold off input while in reset so no request is dropped
    assign s_axis_tready = aresetn
                           && ((32'(cnt_reg) + 32'(p1_v_reg) < 32'd2) || pop);

    always_comb begin
        cnt_next = cnt_reg + 2'(p1_v_reg) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        if (pop) begin
            q_reg[0] <= (cnt_reg == 2'd2) ? q_reg[1] : p1_word;
            if (cnt_reg == 2'd2 && p1_v_reg) q_reg[1] <= p1_word;
        end else if (p1_v_reg) begin
            if (cnt_reg == 2'd0) q_reg[0] <= p1_word;
            else                 q_reg[1] <= p1_word;
        end
    end
endmodule
`default_nettype wire

>>> hdl/sse_checker.sv
`default_nettype none
module sse_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status");
    a_evlen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[20:3] == 18'd0)
        else $error("lengths without event");
    a_evread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[28:21] == 8'd0)
        else $error("read byte on dispatch");
    a_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("no result after request");
endmodule

bind sse_event_stream_parser sse_checker u_sse_checker (.*);
`default_nettype wire
